[hdl/cptc_pkg.sv]
// ----------------------------------------------------------------------------
// cptc_pkg
// shared types and constants for the constant pool tag checker
// ----------------------------------------------------------------------------
package cptc_pkg;

   // default pool depth in slots
   localparam int POOL_SLOTS_DEFAULT = 4096;

   // field widths
   localparam int TAG_W      = 8;
   localparam int REF_W      = 16;
   localparam int SLOT_OUT_W = 12;
   localparam int KIND_W     = 3;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 8;

   // slot tags
   localparam logic [TAG_W-1:0] TAG_UTF8       = 8'd1;
   localparam logic [TAG_W-1:0] TAG_INT        = 8'd3;
   localparam logic [TAG_W-1:0] TAG_FLOAT      = 8'd4;
   localparam logic [TAG_W-1:0] TAG_LONG       = 8'd5;
   localparam logic [TAG_W-1:0] TAG_DOUBLE     = 8'd6;
   localparam logic [TAG_W-1:0] TAG_CLASS      = 8'd7;
   localparam logic [TAG_W-1:0] TAG_STRING     = 8'd8;
   localparam logic [TAG_W-1:0] TAG_FIELDREF   = 8'd9;
   localparam logic [TAG_W-1:0] TAG_METHODREF  = 8'd10;
   localparam logic [TAG_W-1:0] TAG_IMETHODREF = 8'd11;
   localparam logic [TAG_W-1:0] TAG_NAMETYPE   = 8'd12;

   // error kinds
   localparam logic [KIND_W-1:0] ERR_NONE       = 3'd0;
   localparam logic [KIND_W-1:0] ERR_BAD_TAG    = 3'd1;
   localparam logic [KIND_W-1:0] ERR_BAD_CLASS  = 3'd2;
   localparam logic [KIND_W-1:0] ERR_BAD_NT     = 3'd3;
   localparam logic [KIND_W-1:0] ERR_BAD_NAME   = 3'd4;
   localparam logic [KIND_W-1:0] ERR_BAD_DESC   = 3'd5;
   localparam logic [KIND_W-1:0] ERR_RANGE      = 3'd6;
   localparam logic [KIND_W-1:0] ERR_OVERFLOW   = 3'd7;

   // configuration register indexes and reset values
   localparam logic [CSR_IDX_W-1:0]  CSR_RESOLVED_CLASS  = 4'd0;
   localparam logic [CSR_IDX_W-1:0]  CSR_RESOLVED_STRING = 4'd1;
   localparam logic [CSR_DATA_W-1:0] RESOLVED_CLASS_RST  = 8'd23;
   localparam logic [CSR_DATA_W-1:0] RESOLVED_STRING_RST = 8'd24;

   // walk sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DECODE,
      ST_CHK_A,
      ST_CHK_B
   } state_type;

endpackage

[hdl/cptc_ram.sv]
// ----------------------------------------------------------------------------
// cptc_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module cptc_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/constant_pool_tag_checker.sv]
// ----------------------------------------------------------------------------
// constant_pool_tag_checker
// loads constant pool slots and walks them for tag consistency
// ----------------------------------------------------------------------------
// usage
//   request channel: start with req_* fields is taken when busy is low. each
//   transfer loads one slot, from slot 1 upward, while the pool has room, so
//   a pool streams in at one slot per clock.
//   the transfer with req_last_entry set starts the check. busy goes high
//   the next cycle while the walk runs over the tag and ref memories; the
//   single tag memory read port is the shared resource of the walk.
//   walk steps: a plain, long or double slot passes fetch and decode; a
//   reference or name-and-type slot passes fetch, decode, chk_a and chk_b;
//   a final fetch reports. the walk stops at the first error. an overflowed
//   pool reports in the cycle after the last transfer without a walk.
//   response channel: rsp_valid is high for exactly one cycle with the
//   verdict; the receiver cannot stall it. busy drops in that same cycle,
//   so the next pool can start right away.
//   csr channel: csr_ready is always high; the user must write only while idle, as the block does not enforce it.
//   reset: synchronous, clears the sequencer, slot count, overflow flag and
//   presets the resolved-tag registers. memories need no clearing pass.
// ----------------------------------------------------------------------------
module constant_pool_tag_checker #(
   parameter int POOL_SLOTS = cptc_pkg::POOL_SLOTS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             start,
   output logic                             busy,
   input  logic [cptc_pkg::TAG_W-1:0]       req_entry_tag,
   input  logic [cptc_pkg::REF_W-1:0]       req_first_ref,
   input  logic [cptc_pkg::REF_W-1:0]       req_second_ref,
   input  logic                             req_last_entry,
   // response channel
   output logic                             rsp_valid,
   output logic                             rsp_pool_ok,
   output logic [cptc_pkg::SLOT_OUT_W-1:0]  rsp_error_slot,
   output logic [cptc_pkg::KIND_W-1:0]      rsp_error_kind,
   // csr channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cptc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cptc_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int ADDR_W = $clog2(POOL_SLOTS);
   localparam int IDX_W  = ADDR_W + 1;
   localparam int CMP_W  = cptc_pkg::REF_W + 1;
   localparam int TAG_W  = cptc_pkg::TAG_W;
   localparam int REF2_W = 2 * cptc_pkg::REF_W;
   localparam int SOW    = cptc_pkg::SLOT_OUT_W;

   // sequencer and pool state
   cptc_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [ADDR_W-1:0]   count_ff, count_in;
   logic                ovf_ff, ovf_in;
   logic                is_ref_ff, is_ref_in;
   logic                rd_zero_ff, rd_zero_in;

   // resolved-tag registers
   logic [TAG_W-1:0]    class_code_ff, class_code_in;
   logic [TAG_W-1:0]    string_code_ff, string_code_in;

   // response registers
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_ok_ff, rsp_ok_in;
   logic [SOW-1:0]      rsp_slot_ff, rsp_slot_in;
   logic [cptc_pkg::KIND_W-1:0] rsp_kind_ff, rsp_kind_in;

   // memory ports
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr;
   logic [ADDR_W-1:0]   tag_raddr;
   logic [ADDR_W-1:0]   ref_raddr;
   logic [TAG_W-1:0]    tag_rd;
   logic [REF2_W-1:0]   ref_rd;

   // decode and shared compare
   logic                accept;
   logic [IDX_W-1:0]    load_slot;
   logic                load_fits;
   logic [TAG_W-1:0]    tag_val;
   logic [cptc_pkg::REF_W-1:0] ref_a, ref_b, chk_ref;
   logic                chk_over;
   logic                dec_ref, dec_nt, dec_wide, dec_plain;
   logic                match_a, match_b;
   logic                walk_done;
   logic [IDX_W+SOW-1:0] idx_wide;

   cptc_ram #(
      .WIDTH (TAG_W),
      .DEPTH (POOL_SLOTS),
      .ADDR_W(ADDR_W)
   ) u_tag_ram (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(req_entry_tag),
      .rd_addr(tag_raddr),
      .rd_data(tag_rd)
   );

   cptc_ram #(
      .WIDTH (REF2_W),
      .DEPTH (POOL_SLOTS),
      .ADDR_W(ADDR_W)
   ) u_ref_ram (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data({req_second_ref, req_first_ref}),
      .rd_addr(ref_raddr),
      .rd_data(ref_rd)
   );

   assign busy      = (state_ff != cptc_pkg::ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // next load slot, dropped once the pool is full
   assign load_slot = IDX_W'(count_ff) + IDX_W'(1);
   assign load_fits = !ovf_ff && (load_slot < IDX_W'(POOL_SLOTS));

   // slot zero is never written and always reads as tag 0
   assign tag_val = rd_zero_ff ? '0 : tag_rd;
   assign ref_a   = ref_rd[cptc_pkg::REF_W-1:0];
   assign ref_b   = ref_rd[REF2_W-1:cptc_pkg::REF_W];

   // shared range compare: first ref in decode, second ref afterwards
   assign chk_ref  = (state_ff == cptc_pkg::ST_DECODE) ? ref_a : ref_b;
   assign chk_over = CMP_W'(chk_ref) > CMP_W'(count_ff);

   // fixed tags first, resolved codes only for the rest
   assign dec_ref  = (tag_val == cptc_pkg::TAG_FIELDREF) ||
                     (tag_val == cptc_pkg::TAG_METHODREF) ||
                     (tag_val == cptc_pkg::TAG_IMETHODREF);
   assign dec_nt   = (tag_val == cptc_pkg::TAG_NAMETYPE);
   assign dec_wide = (tag_val == cptc_pkg::TAG_LONG) ||
                     (tag_val == cptc_pkg::TAG_DOUBLE);
   assign dec_plain = (tag_val == cptc_pkg::TAG_UTF8) ||
                      (tag_val == cptc_pkg::TAG_INT) ||
                      (tag_val == cptc_pkg::TAG_FLOAT) ||
                      (tag_val == cptc_pkg::TAG_CLASS) ||
                      (tag_val == cptc_pkg::TAG_STRING) ||
                      (tag_val == class_code_ff) ||
                      (tag_val == string_code_ff);

   // target tag checks for the two references of the current slot
   assign match_a = is_ref_ff ?
                    ((tag_val == cptc_pkg::TAG_CLASS) || (tag_val == class_code_ff)) :
                    (tag_val == cptc_pkg::TAG_UTF8);
   assign match_b = is_ref_ff ? (tag_val == cptc_pkg::TAG_NAMETYPE) :
                                (tag_val == cptc_pkg::TAG_UTF8);

   // count is below the pool depth, so this also bounds the index
   assign walk_done = idx_ff > IDX_W'(count_ff);
   assign idx_wide  = {{SOW{1'b0}}, idx_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cptc_pkg::ST_IDLE: begin
            if (accept && req_last_entry && load_fits) begin
               state_in = cptc_pkg::ST_FETCH;
            end
         end
         cptc_pkg::ST_FETCH: begin
            state_in = walk_done ? cptc_pkg::ST_IDLE : cptc_pkg::ST_DECODE;
         end
         cptc_pkg::ST_DECODE: begin
            if (dec_ref || dec_nt) begin
               state_in = chk_over ? cptc_pkg::ST_IDLE : cptc_pkg::ST_CHK_A;
            end else if (dec_wide || dec_plain) begin
               state_in = cptc_pkg::ST_FETCH;
            end else begin
               state_in = cptc_pkg::ST_IDLE;
            end
         end
         cptc_pkg::ST_CHK_A: begin
            state_in = (!match_a || chk_over) ? cptc_pkg::ST_IDLE : cptc_pkg::ST_CHK_B;
         end
         cptc_pkg::ST_CHK_B: begin
            state_in = match_b ? cptc_pkg::ST_FETCH : cptc_pkg::ST_IDLE;
         end
         default: begin
            state_in = cptc_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      idx_in       = idx_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      is_ref_in    = is_ref_ff;
      rsp_valid_in = 1'b0;
      rsp_ok_in    = rsp_ok_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_kind_in  = rsp_kind_ff;
      mem_we       = 1'b0;
      mem_waddr    = load_slot[ADDR_W-1:0];
      tag_raddr    = idx_ff[ADDR_W-1:0];
      ref_raddr    = idx_ff[ADDR_W-1:0];

      unique case (state_ff)
         cptc_pkg::ST_IDLE: begin
            if (accept) begin
               if (load_fits) begin
                  mem_we   = 1'b1;
                  count_in = load_slot[ADDR_W-1:0];
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last_entry) begin
                  if (load_fits) begin
                     idx_in = IDX_W'(1);
                  end else begin
                     // overflowed pool: report without a walk
                     rsp_valid_in = 1'b1;
                     rsp_ok_in    = 1'b0;
                     rsp_slot_in  = '0;
                     rsp_kind_in  = cptc_pkg::ERR_OVERFLOW;
                     count_in     = '0;
                     ovf_in       = 1'b0;
                  end
               end
            end
         end
         cptc_pkg::ST_FETCH: begin
            if (walk_done) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b1;
               rsp_slot_in  = '0;
               rsp_kind_in  = cptc_pkg::ERR_NONE;
               count_in     = '0;
            end
         end
         cptc_pkg::ST_DECODE: begin
            tag_raddr = ref_a[ADDR_W-1:0];
            is_ref_in = dec_ref;
            if (dec_ref || dec_nt) begin
               if (chk_over) begin
                  rsp_valid_in = 1'b1;
                  rsp_ok_in    = 1'b0;
                  rsp_slot_in  = idx_wide[SOW-1:0];
                  rsp_kind_in  = cptc_pkg::ERR_RANGE;
                  count_in     = '0;
               end
            end else if (dec_wide) begin
               // long and double take two slots
               idx_in = idx_ff + IDX_W'(2);
            end else if (dec_plain) begin
               idx_in = idx_ff + IDX_W'(1);
            end else begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b0;
               rsp_slot_in  = idx_wide[SOW-1:0];
               rsp_kind_in  = cptc_pkg::ERR_BAD_TAG;
               count_in     = '0;
            end
         end
         cptc_pkg::ST_CHK_A: begin
            tag_raddr = ref_b[ADDR_W-1:0];
            if (!match_a) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b0;
               rsp_slot_in  = idx_wide[SOW-1:0];
               rsp_kind_in  = is_ref_ff ? cptc_pkg::ERR_BAD_CLASS : cptc_pkg::ERR_BAD_NAME;
               count_in     = '0;
            end else if (chk_over) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b0;
               rsp_slot_in  = idx_wide[SOW-1:0];
               rsp_kind_in  = cptc_pkg::ERR_RANGE;
               count_in     = '0;
            end
         end
         cptc_pkg::ST_CHK_B: begin
            if (match_b) begin
               idx_in = idx_ff + IDX_W'(1);
            end else begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b0;
               rsp_slot_in  = idx_wide[SOW-1:0];
               rsp_kind_in  = is_ref_ff ? cptc_pkg::ERR_BAD_NT : cptc_pkg::ERR_BAD_DESC;
               count_in     = '0;
            end
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase

      rd_zero_in = (tag_raddr == '0);
   end

   // configuration writes, other indexes are ignored
   always_comb begin
      class_code_in  = class_code_ff;
      string_code_in = string_code_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == cptc_pkg::CSR_RESOLVED_CLASS) begin
            class_code_in = csr_data;
         end else if (csr_index == cptc_pkg::CSR_RESOLVED_STRING) begin
            string_code_in = csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= cptc_pkg::ST_IDLE;
         count_ff       <= '0;
         ovf_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         class_code_ff  <= cptc_pkg::RESOLVED_CLASS_RST;
         string_code_ff <= cptc_pkg::RESOLVED_STRING_RST;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         ovf_ff         <= ovf_in;
         rsp_valid_ff   <= rsp_valid_in;
         class_code_ff  <= class_code_in;
         string_code_ff <= string_code_in;
      end
      idx_ff      <= idx_in;
      is_ref_ff   <= is_ref_in;
      rd_zero_ff  <= rd_zero_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_kind_ff <= rsp_kind_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pool_ok    = rsp_ok_ff;
   assign rsp_error_slot = rsp_slot_ff;
   assign rsp_error_kind = rsp_kind_ff;

endmodule
